@@ sv/gewr_pkg.sv @@
// Package for the grid-to-earth wind rotation block: widths, reset values,
// register indexes and the arctangent table of the rotation pipeline.
// Depends on nothing; every other file of the block uses it.
package gewr_pkg;

   localparam int ITERATIONS_DEFAULT = 16;
   localparam int ITERATIONS_MAX     = 24;

   localparam int WIND_W      = 32;
   localparam int LON_W       = 25;
   localparam int CONE_W      = 16;
   localparam int DIFF_W      = LON_W + 1;
   localparam int PROD_W      = CONE_W + DIFF_W;
   localparam int MAG_W       = PROD_W - 1;
   localparam int LO_W        = 20;
   localparam int HI_W        = MAG_W - LO_W;
   localparam int QH_W        = 14;
   localparam int RH_W        = 8;
   localparam int REM_W       = RH_W + LO_W;
   localparam int Q2_W        = LO_W;
   localparam int QUOT_W      = QH_W + Q2_W;
   localparam int ANGLE_W     = 32;
   localparam int CORDIC_W    = 33;
   localparam int COEF_W      = 32;
   localparam int TERM_W      = COEF_W + WIND_W;
   localparam int SUM_W       = TERM_W + 1;
   localparam int OUT_SHIFT   = 30;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam logic signed [CONE_W-1:0] CONE_RESET    = 16'sd20399;
   localparam logic signed [LON_W-1:0]  CENTER_RESET  = -25'sd6389760;
   localparam logic signed [WIND_W-1:0] MISSING_RESET = -32'sd25574400;
   localparam logic signed [WIND_W-1:0] UNAVAIL_RESET = -32'sd25575168;

   localparam int DIV_CONST    = 180;
   localparam int ROUND_HALF   = 90;
   localparam int RECIP_HI     = (1 << HI_W) / DIV_CONST;
   localparam int RECIP_LO     = (1 << REM_W) / DIV_CONST;
   localparam int RECIP_HI_W   = 14;
   localparam int RECIP_LO_W   = 21;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic [SUM_W-1:0] ROUND_Q38 = SUM_W'(1) << (OUT_SHIFT - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CONE    = 2'd0,
      CSR_CENTER  = 2'd1,
      CSR_MISSING = 2'd2,
      CSR_UNAVAIL = 2'd3
   } csr_index_type;

   // Arctangent of 2^-i in binary angle units (2^32 per turn).
   function automatic logic [ANGLE_W-1:0] atan_turn(input int idx);
      logic [ANGLE_W-1:0] val;
      case (idx)
         0:       val = 32'd536870912;
         1:       val = 32'd316933406;
         2:       val = 32'd167458907;
         3:       val = 32'd85004756;
         4:       val = 32'd42667331;
         5:       val = 32'd21354465;
         6:       val = 32'd10679838;
         7:       val = 32'd5340245;
         8:       val = 32'd2670163;
         9:       val = 32'd1335087;
         10:      val = 32'd667544;
         11:      val = 32'd333772;
         12:      val = 32'd166886;
         13:      val = 32'd83443;
         14:      val = 32'd41722;
         15:      val = 32'd20861;
         16:      val = 32'd10430;
         17:      val = 32'd5215;
         18:      val = 32'd2608;
         19:      val = 32'd1304;
         20:      val = 32'd652;
         21:      val = 32'd326;
         22:      val = 32'd163;
         23:      val = 32'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/gewr_if.sv @@
// Channel interfaces of the wind rotation block: grid point requests and
// rotated wind responses, each with valid, ready and payload.
// Depends on gewr_pkg for the field widths.
interface gewr_req_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [gewr_pkg::WIND_W-1:0]        u_grid;
   logic signed [gewr_pkg::WIND_W-1:0]        v_grid;
   logic signed [gewr_pkg::LON_W-1:0]         point_longitude;

   modport source (output valid, u_grid, v_grid, point_longitude, input ready);
   modport sink (input valid, u_grid, v_grid, point_longitude, output ready);
endinterface

interface gewr_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic signed [gewr_pkg::WIND_W-1:0]        u_earth;
   logic signed [gewr_pkg::WIND_W-1:0]        v_earth;
   logic                                      passed_through;

   modport source (output valid, u_earth, v_earth, passed_through, input ready);
   modport sink (input valid, u_earth, v_earth, passed_through, output ready);
endinterface

@@ sv/grid_to_earth_wind_rotation.sv @@
// Top level of the grid-to-earth wind rotation block.
// Depends on gewr_pkg and on the channel interfaces in gewr_if.sv.
//
// Each request transfer on req_ch carries one grid point: grid-relative U and
// V wind (Q8) and the point's longitude (Q16 degrees). Each brings exactly one
// response transfer on rsp_ch, in order, with earth-relative U and V (Q8,
// saturated). When either component matches the missing or unavailable code,
// both components come back unchanged and passed_through is set.
// The csr port writes the cone factor, the central longitude and the two
// sentinel codes; write only while no point is in flight.
// The pipeline has ROTATION_ITERATIONS + 11 stages: accept, cone product,
// magnitude, two stages for each half of the division by 180, the angle
// fold, one stage per rotation step, sign, products and rounding. One point
// can enter every cycle while the receiver is not stalling rsp_ch. When the
// receiver stalls, items close up into empty stages, so req_ch stays ready
// until every stage holds an item. Reset empties the pipeline and restores
// the register defaults.
module grid_to_earth_wind_rotation #(
   parameter int ROTATION_ITERATIONS = gewr_pkg::ITERATIONS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [gewr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gewr_pkg::CSR_DATA_W-1:0]    csr_wdata,
   gewr_req_if.sink                           req_ch,
   gewr_rsp_if.source                         rsp_ch
);

   localparam int WW = gewr_pkg::WIND_W;
   localparam int CW = gewr_pkg::CORDIC_W;

   localparam int S_ACCEPT = 0;
   localparam int S_PROD   = 1;
   localparam int S_MAG    = 2;
   localparam int S_QH_EST = 3;
   localparam int S_QH     = 4;
   localparam int S_Q2_EST = 5;
   localparam int S_Q2     = 6;
   localparam int S_FOLD   = 7;
   localparam int S_CORDIC = 8;
   localparam int S_SIGN   = S_CORDIC + ROTATION_ITERATIONS;
   localparam int S_MUL    = S_SIGN + 1;
   localparam int S_OUT    = S_MUL + 1;
   localparam int STAGES   = S_OUT + 1;

   // Configuration registers.
   logic signed [gewr_pkg::CONE_W-1:0] cone_ff;
   logic signed [gewr_pkg::LON_W-1:0]  center_ff;
   logic signed [WW-1:0]               missing_ff;
   logic signed [WW-1:0]               unavail_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cone_ff    <= gewr_pkg::CONE_RESET;
         center_ff  <= gewr_pkg::CENTER_RESET;
         missing_ff <= gewr_pkg::MISSING_RESET;
         unavail_ff <= gewr_pkg::UNAVAIL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            gewr_pkg::CSR_CONE:    cone_ff    <= csr_wdata[gewr_pkg::CONE_W-1:0];
            gewr_pkg::CSR_CENTER:  center_ff  <= csr_wdata[gewr_pkg::LON_W-1:0];
            gewr_pkg::CSR_MISSING: missing_ff <= csr_wdata[WW-1:0];
            gewr_pkg::CSR_UNAVAIL: unavail_ff <= csr_wdata[WW-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline control: a stage loads when it is empty or its successor loads.
   logic [STAGES-1:0] valid_ff;
   logic [STAGES-1:0] stage_en;

   always_comb begin
      stage_en[STAGES-1] = !valid_ff[STAGES-1] || rsp_ch.ready;
      for (int k = STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   assign req_ch.ready = stage_en[S_ACCEPT];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (stage_en[S_ACCEPT]) begin
            valid_ff[S_ACCEPT] <= req_ch.valid;
         end
         for (int k = 1; k < STAGES; k++) begin
            if (stage_en[k]) begin
               valid_ff[k] <= valid_ff[k-1];
            end
         end
      end
   end

   // Wind components and the sentinel flag travel with every item.
   logic signed [WW-1:0] u_pipe_ff  [S_OUT];
   logic signed [WW-1:0] v_pipe_ff  [S_OUT];
   logic                 pt_pipe_ff [S_OUT];
   logic                 sentinel_in;

   assign sentinel_in = (req_ch.u_grid == missing_ff) || (req_ch.u_grid == unavail_ff) ||
                        (req_ch.v_grid == missing_ff) || (req_ch.v_grid == unavail_ff);

   always_ff @(posedge clock) begin
      if (stage_en[S_ACCEPT]) begin
         u_pipe_ff[S_ACCEPT]  <= req_ch.u_grid;
         v_pipe_ff[S_ACCEPT]  <= req_ch.v_grid;
         pt_pipe_ff[S_ACCEPT] <= sentinel_in;
      end
      for (int k = 1; k < S_OUT; k++) begin
         if (stage_en[k]) begin
            u_pipe_ff[k]  <= u_pipe_ff[k-1];
            v_pipe_ff[k]  <= v_pipe_ff[k-1];
            pt_pipe_ff[k] <= pt_pipe_ff[k-1];
         end
      end
   end

   // Longitude difference and cone product.
   logic signed [gewr_pkg::DIFF_W-1:0] diff_in, diff_ff;
   logic signed [gewr_pkg::PROD_W-1:0] prod_in, prod_ff;

   assign diff_in = gewr_pkg::DIFF_W'(req_ch.point_longitude) -
                    gewr_pkg::DIFF_W'(center_ff);
   assign prod_in = gewr_pkg::PROD_W'(cone_ff) * gewr_pkg::PROD_W'(diff_ff);

   always_ff @(posedge clock) begin
      if (stage_en[S_ACCEPT]) begin
         diff_ff <= diff_in;
      end
      if (stage_en[S_PROD]) begin
         prod_ff <= prod_in;
      end
   end

   // Division by 180 with rounding half away from zero, on the magnitude.
   // The magnitude is split in a high and a low half; each half is divided
   // by a reciprocal multiplication followed by a one-step correction.
   logic signed [gewr_pkg::PROD_W-1:0]    prod_abs;
   logic [gewr_pkg::MAG_W-1:0]            mag_in, mag_ff;
   logic [S_Q2:S_MAG]                     div_neg_ff;
   logic [gewr_pkg::HI_W-1:0]             hi_ff;
   logic [gewr_pkg::LO_W-1:0]             lo_ff;
   logic [gewr_pkg::QH_W-1:0]             qh_est_in, qh_est_ff;
   logic [gewr_pkg::HI_W-1:0]             rh_full;
   logic [gewr_pkg::HI_W-1:0]             rh_fix;
   logic [gewr_pkg::QH_W-1:0]             qh_in, qh_ff, qh_s5_ff;
   logic [gewr_pkg::REM_W-1:0]            rem2_in, rem2_ff, rem2_s5_ff;
   logic [gewr_pkg::Q2_W-1:0]             q2_est_in, q2_est_ff, q2_in;
   logic [gewr_pkg::REM_W-1:0]            r2_full;
   logic [gewr_pkg::QUOT_W-1:0]           quot_ff;

   localparam int RHP_W = gewr_pkg::HI_W + gewr_pkg::RECIP_HI_W;
   localparam int RLP_W = gewr_pkg::REM_W + gewr_pkg::RECIP_LO_W;

   always_comb begin
      prod_abs  = prod_ff[gewr_pkg::PROD_W-1] ? -prod_ff : prod_ff;
      mag_in    = prod_abs[gewr_pkg::MAG_W-1:0] + gewr_pkg::MAG_W'(gewr_pkg::ROUND_HALF);
      qh_est_in = gewr_pkg::QH_W'((RHP_W'(mag_ff[gewr_pkg::MAG_W-1:gewr_pkg::LO_W]) *
                                   RHP_W'(gewr_pkg::RECIP_HI)) >> gewr_pkg::HI_W);
      rh_full   = hi_ff - gewr_pkg::HI_W'(qh_est_ff) * gewr_pkg::HI_W'(gewr_pkg::DIV_CONST);
      if (rh_full >= gewr_pkg::HI_W'(gewr_pkg::DIV_CONST)) begin
         qh_in  = qh_est_ff + 1'b1;
         rh_fix = rh_full - gewr_pkg::HI_W'(gewr_pkg::DIV_CONST);
      end else begin
         qh_in  = qh_est_ff;
         rh_fix = rh_full;
      end
      rem2_in   = {rh_fix[gewr_pkg::RH_W-1:0], lo_ff};
      q2_est_in = gewr_pkg::Q2_W'((RLP_W'(rem2_ff) * RLP_W'(gewr_pkg::RECIP_LO))
                                  >> gewr_pkg::REM_W);
      r2_full   = rem2_s5_ff -
                  gewr_pkg::REM_W'(q2_est_ff) * gewr_pkg::REM_W'(gewr_pkg::DIV_CONST);
      if (r2_full >= gewr_pkg::REM_W'(gewr_pkg::DIV_CONST)) begin
         q2_in = q2_est_ff + 1'b1;
      end else begin
         q2_in = q2_est_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[S_MAG]) begin
         mag_ff            <= mag_in;
         div_neg_ff[S_MAG] <= prod_ff[gewr_pkg::PROD_W-1];
      end
      for (int k = S_MAG + 1; k <= S_Q2; k++) begin
         if (stage_en[k]) begin
            div_neg_ff[k] <= div_neg_ff[k-1];
         end
      end
      if (stage_en[S_QH_EST]) begin
         qh_est_ff <= qh_est_in;
         hi_ff     <= mag_ff[gewr_pkg::MAG_W-1:gewr_pkg::LO_W];
         lo_ff     <= mag_ff[gewr_pkg::LO_W-1:0];
      end
      if (stage_en[S_QH]) begin
         qh_ff   <= qh_in;
         rem2_ff <= rem2_in;
      end
      if (stage_en[S_Q2_EST]) begin
         q2_est_ff  <= q2_est_in;
         qh_s5_ff   <= qh_ff;
         rem2_s5_ff <= rem2_ff;
      end
      if (stage_en[S_Q2]) begin
         quot_ff <= {qh_s5_ff, q2_in};
      end
   end

   // Binary angle, folded into the right half plane.
   logic [gewr_pkg::ANGLE_W-1:0]        angle;
   logic                                fold_in;
   logic signed [gewr_pkg::ANGLE_W-1:0] z0_in, z0_ff;
   logic [S_SIGN-1:S_FOLD]              flip_ff;

   always_comb begin
      angle   = div_neg_ff[S_Q2] ? -quot_ff[gewr_pkg::ANGLE_W-1:0]
                                 : quot_ff[gewr_pkg::ANGLE_W-1:0];
      fold_in = (angle[31:30] == 2'b01 && (|angle[29:0])) || (angle[31:30] == 2'b10);
      z0_in   = {angle[31] ^ fold_in, angle[30:0]};
   end

   always_ff @(posedge clock) begin
      if (stage_en[S_FOLD]) begin
         z0_ff           <= z0_in;
         flip_ff[S_FOLD] <= fold_in;
      end
      for (int k = S_FOLD + 1; k < S_SIGN; k++) begin
         if (stage_en[k]) begin
            flip_ff[k] <= flip_ff[k-1];
         end
      end
   end

   // Rotation steps, one pipeline stage each.
   logic signed [CW-1:0] x_ff [ROTATION_ITERATIONS];
   logic signed [CW-1:0] y_ff [ROTATION_ITERATIONS];
   logic signed [CW-1:0] z_ff [ROTATION_ITERATIONS-1];

   for (genvar i = 0; i < ROTATION_ITERATIONS; i++) begin : g_step
      localparam logic signed [CW-1:0] ATAN_STEP = CW'(gewr_pkg::atan_turn(i));
      logic signed [CW-1:0] x_src, y_src, z_src, x_in, y_in;

      if (i == 0) begin : g_first
         assign x_src = gewr_pkg::CORDIC_GAIN;
         assign y_src = '0;
         assign z_src = CW'(z0_ff);
      end else begin : g_next
         assign x_src = x_ff[i-1];
         assign y_src = y_ff[i-1];
         assign z_src = z_ff[i-1];
      end

      always_comb begin
         if (!z_src[CW-1]) begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
         end else begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
         end
      end

      always_ff @(posedge clock) begin
         if (stage_en[S_CORDIC+i]) begin
            x_ff[i] <= x_in;
            y_ff[i] <= y_in;
         end
      end

      if (i < ROTATION_ITERATIONS - 1) begin : g_angle
         logic signed [CW-1:0] z_in;
         assign z_in = z_src[CW-1] ? z_src + ATAN_STEP : z_src - ATAN_STEP;
         always_ff @(posedge clock) begin
            if (stage_en[S_CORDIC+i]) begin
               z_ff[i] <= z_in;
            end
         end
      end
   end

   // Undo the fold, then form the four products.
   logic signed [CW-1:0]                    ca_full, sb_full;
   logic signed [gewr_pkg::COEF_W-1:0]      ca_ff, sb_ff;
   logic signed [gewr_pkg::TERM_W-1:0]      cu_ff, sv_ff, su_ff, cv_ff;

   always_comb begin
      ca_full = flip_ff[S_SIGN-1] ? -x_ff[ROTATION_ITERATIONS-1] : x_ff[ROTATION_ITERATIONS-1];
      sb_full = flip_ff[S_SIGN-1] ? -y_ff[ROTATION_ITERATIONS-1] : y_ff[ROTATION_ITERATIONS-1];
   end

   always_ff @(posedge clock) begin
      if (stage_en[S_SIGN]) begin
         ca_ff <= ca_full[gewr_pkg::COEF_W-1:0];
         sb_ff <= sb_full[gewr_pkg::COEF_W-1:0];
      end
      if (stage_en[S_MUL]) begin
         cu_ff <= gewr_pkg::TERM_W'(ca_ff) * gewr_pkg::TERM_W'(u_pipe_ff[S_SIGN]);
         sv_ff <= gewr_pkg::TERM_W'(sb_ff) * gewr_pkg::TERM_W'(v_pipe_ff[S_SIGN]);
         su_ff <= gewr_pkg::TERM_W'(sb_ff) * gewr_pkg::TERM_W'(u_pipe_ff[S_SIGN]);
         cv_ff <= gewr_pkg::TERM_W'(ca_ff) * gewr_pkg::TERM_W'(v_pipe_ff[S_SIGN]);
      end
   end

   // Round to Q8, saturate, and select the pass-through values.
   localparam int SH_W = gewr_pkg::SUM_W - gewr_pkg::OUT_SHIFT;

   function automatic logic signed [WW-1:0] saturate(input logic signed [SH_W-1:0] val);
      logic signed [WW-1:0] res;
      if (val > SH_W'(signed'({1'b0, {(WW-1){1'b1}}}))) begin
         res = {1'b0, {(WW-1){1'b1}}};
      end else if (val < -SH_W'(signed'({1'b0, {(WW-1){1'b1}}})) - SH_W'(1)) begin
         res = {1'b1, {(WW-1){1'b0}}};
      end else begin
         res = val[WW-1:0];
      end
      return res;
   endfunction

   logic signed [gewr_pkg::SUM_W-1:0] sum_u, sum_v;
   logic signed [WW-1:0]              u_earth_in, v_earth_in, u_earth_ff, v_earth_ff;
   logic                              pt_ff;

   always_comb begin
      sum_u = gewr_pkg::SUM_W'(cu_ff) + gewr_pkg::SUM_W'(sv_ff) + signed'(gewr_pkg::ROUND_Q38);
      sum_v = gewr_pkg::SUM_W'(cv_ff) - gewr_pkg::SUM_W'(su_ff) + signed'(gewr_pkg::ROUND_Q38);
      if (pt_pipe_ff[S_MUL]) begin
         u_earth_in = u_pipe_ff[S_MUL];
         v_earth_in = v_pipe_ff[S_MUL];
      end else begin
         u_earth_in = saturate(sum_u[gewr_pkg::SUM_W-1:gewr_pkg::OUT_SHIFT]);
         v_earth_in = saturate(sum_v[gewr_pkg::SUM_W-1:gewr_pkg::OUT_SHIFT]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[S_OUT]) begin
         u_earth_ff <= u_earth_in;
         v_earth_ff <= v_earth_in;
         pt_ff      <= pt_pipe_ff[S_MUL];
      end
   end

   assign rsp_ch.valid          = valid_ff[S_OUT];
   assign rsp_ch.u_earth        = u_earth_ff;
   assign rsp_ch.v_earth        = v_earth_ff;
   assign rsp_ch.passed_through = pt_ff;

endmodule

@@ sv/gewr_checker.sv @@
// Port checker for the wind rotation block, attached by the bind below.
// Depends on gewr_pkg and on the top level grid_to_earth_wind_rotation.
module gewr_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic signed [gewr_pkg::WIND_W-1:0] rsp_u_earth,
   input logic signed [gewr_pkg::WIND_W-1:0] rsp_v_earth,
   input logic                              rsp_passed_through
);

   // Reset empties the pipeline, so no response follows it directly.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // An empty or draining output stage always lets a request in.
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request stalled while the output stage can move");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_u_earth) && $stable(rsp_v_earth) && $stable(rsp_passed_through)))
      else $error("response payload changed while stalled");

   a_ready_known: assert property (@(posedge clock) disable iff (reset)
      req_valid |-> !$isunknown(req_ready))
      else $error("request ready unknown while a request is offered");

endmodule

bind grid_to_earth_wind_rotation gewr_checker u_gewr_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_u_earth        (rsp_ch.u_earth),
   .rsp_v_earth        (rsp_ch.v_earth),
   .rsp_passed_through (rsp_ch.passed_through)
);

@@ verif/tb_grid_to_earth_wind_rotation.sv @@
// Self-checking testbench for grid_to_earth_wind_rotation: directed and random grid
// points against a cycle-free rotation predictor, with random stalls on both channels.
// Depends on gewr_pkg and the channel interfaces in gewr_if.sv.
`timescale 1ns / 1ps

package gewr_tb_pkg;

   localparam int     ATAN_LEN       = 24;
   localparam longint QUARTER_BAM    = 64'sd1073741824;
   localparam longint HALF_BAM       = 64'sd2147483648;
   localparam longint GAIN_Q30       = 64'sd652032874;
   localparam longint ROUND_Q8       = 64'sd536870912;
   localparam longint INT32_TOP      = 64'sd2147483647;
   localparam longint INT32_BOTTOM   = -64'sd2147483648;

   localparam longint ATAN_BAM [ATAN_LEN] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   typedef struct packed {
      logic signed [gewr_pkg::WIND_W-1:0] u_grid;
      logic signed [gewr_pkg::WIND_W-1:0] v_grid;
      logic signed [gewr_pkg::LON_W-1:0]  point_longitude;
   } grid_point_type;

   typedef struct packed {
      logic signed [gewr_pkg::WIND_W-1:0] u_earth;
      logic signed [gewr_pkg::WIND_W-1:0] v_earth;
      logic                               passed_through;
   } earth_wind_type;

   class wind_scoreboard_type;
      int                                 steps;
      logic signed [gewr_pkg::CONE_W-1:0] cone;
      logic signed [gewr_pkg::LON_W-1:0]  center_lon;
      logic signed [gewr_pkg::WIND_W-1:0] missing_word;
      logic signed [gewr_pkg::WIND_W-1:0] unavail_word;
      earth_wind_type                     expected_winds[$];
      int unsigned                        failures;

      function new(int rotation_steps);
         steps        = rotation_steps;
         cone         = gewr_pkg::CONE_RESET;
         center_lon   = gewr_pkg::CENTER_RESET;
         missing_word = gewr_pkg::MISSING_RESET;
         unavail_word = gewr_pkg::UNAVAIL_RESET;
         failures     = 0;
      endfunction

      function void write_register(gewr_pkg::csr_index_type idx,
                                   logic [gewr_pkg::CSR_DATA_W-1:0] data);
         case (idx)
            gewr_pkg::CSR_CONE:    cone         = data[gewr_pkg::CONE_W-1:0];
            gewr_pkg::CSR_CENTER:  center_lon   = data[gewr_pkg::LON_W-1:0];
            gewr_pkg::CSR_MISSING: missing_word = data[gewr_pkg::WIND_W-1:0];
            gewr_pkg::CSR_UNAVAIL: unavail_word = data[gewr_pkg::WIND_W-1:0];
            default: ;
         endcase
      endfunction

      function logic signed [gewr_pkg::WIND_W-1:0] round_saturate(longint left,
                                                                  longint right);
         longint total;
         total = (left + right + ROUND_Q8) >>> gewr_pkg::OUT_SHIFT;
         if (total > INT32_TOP) total = INT32_TOP;
         if (total < INT32_BOTTOM) total = INT32_BOTTOM;
         return gewr_pkg::WIND_W'(total);
      endfunction

      function earth_wind_type rotate_point(grid_point_type p);
         longint         u, v, lon_diff, deg_q31, turns, z, x, y, dx, dy, cos_a, sin_b;
         logic [31:0]    bam;
         bit             folded;
         earth_wind_type r;
         r.u_earth = p.u_grid;
         r.v_earth = p.v_grid;
         r.passed_through = 1'b1;
         if (p.u_grid == missing_word || p.u_grid == unavail_word ||
             p.v_grid == missing_word || p.v_grid == unavail_word)
            return r;
         u = longint'($signed(p.u_grid));
         v = longint'($signed(p.v_grid));
         lon_diff = longint'($signed(p.point_longitude)) - longint'(center_lon);
         deg_q31 = longint'(cone) * lon_diff;
         if (deg_q31 >= 0) turns = (deg_q31 + 90) / 180;
         else turns = -((90 - deg_q31) / 180);
         bam = 32'(turns);
         z = longint'($signed(bam));
         folded = 1'b0;
         if (z > QUARTER_BAM) begin
            z -= HALF_BAM;
            folded = 1'b1;
         end else if (z < -QUARTER_BAM) begin
            z += HALF_BAM;
            folded = 1'b1;
         end
         x = GAIN_Q30;
         y = 0;
         for (int i = 0; i < steps && i < ATAN_LEN; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx;
               y += dy;
               z -= ATAN_BAM[i];
            end else begin
               x += dx;
               y -= dy;
               z += ATAN_BAM[i];
            end
         end
         cos_a = folded ? -x : x;
         sin_b = folded ? -y : y;
         r.u_earth = round_saturate(cos_a * u, sin_b * v);
         r.v_earth = round_saturate(-sin_b * u, cos_a * v);
         r.passed_through = 1'b0;
         return r;
      endfunction

      function void note_point(grid_point_type p);
         expected_winds = {expected_winds, rotate_point(p)};
      endfunction

      function void mismatch(string field, longint want, longint got);
         failures++;
         $error("%s: expected %0d, actual %0d", field, want, got);
      endfunction

      function void check_wind(logic signed [gewr_pkg::WIND_W-1:0] u,
                               logic signed [gewr_pkg::WIND_W-1:0] v,
                               logic flag);
         earth_wind_type want;
         if (expected_winds.size() == 0) begin
            failures++;
            $error("response transfer with no grid point outstanding");
            return;
         end
         want = expected_winds.pop_front();
         if (want.u_earth !== u) mismatch("u_earth", want.u_earth, u);
         if (want.v_earth !== v) mismatch("v_earth", want.v_earth, v);
         if (want.passed_through !== flag)
            mismatch("passed_through", want.passed_through, flag);
      endfunction

      function int pending_count();
         return expected_winds.size();
      endfunction
   endclass

endpackage

module tb_grid_to_earth_wind_rotation;

   localparam int ROTATION_STEPS    = 16;
   localparam int LONG_STALL_CYCLES = 200;
   localparam int WATCHDOG_LIMIT    = 2000;
   localparam int RANDOM_PHASES     = 8;
   localparam int PHASE_POINTS      = 190;

   localparam logic signed [gewr_pkg::WIND_W-1:0] WIND_MAX = 32'sh7FFFFFFF;
   localparam logic signed [gewr_pkg::WIND_W-1:0] WIND_MIN = 32'sh80000000;
   localparam logic signed [gewr_pkg::LON_W-1:0]  LON_MAX  = 25'sd11796480;
   localparam logic signed [gewr_pkg::LON_W-1:0]  LON_MIN  = -25'sd11796480;
   localparam int                                 DEGREE   = 65536;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            csr_we;
   gewr_pkg::csr_index_type         csr_index;
   logic [gewr_pkg::CSR_DATA_W-1:0] csr_wdata;
   bit                              idling_on;
   bit                              long_stall_req;
   int unsigned                     quiet_cycles;
   gewr_tb_pkg::wind_scoreboard_type sb;

   gewr_req_if req_ch ();
   gewr_rsp_if rsp_ch ();

   grid_to_earth_wind_rotation #(
      .ROTATION_ITERATIONS(ROTATION_STEPS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic load_settings(input logic [gewr_pkg::CONE_W-1:0] cone,
                                input logic [gewr_pkg::LON_W-1:0] center,
                                input logic [gewr_pkg::WIND_W-1:0] missing,
                                input logic [gewr_pkg::WIND_W-1:0] unavail);
      gewr_pkg::csr_index_type         order [4];
      logic [gewr_pkg::CSR_DATA_W-1:0] words [4];
      order = '{gewr_pkg::CSR_CONE, gewr_pkg::CSR_CENTER, gewr_pkg::CSR_MISSING,
                gewr_pkg::CSR_UNAVAIL};
      words[0] = {16'($urandom), cone};
      words[1] = {7'($urandom), center};
      words[2] = missing;
      words[3] = unavail;
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= order[i];
         csr_wdata <= words[i];
         @(posedge clock);
         sb.write_register(order[i], words[i]);
      end
      csr_we <= 1'b0;
   endtask

   task automatic send_point(input logic [gewr_pkg::WIND_W-1:0] u,
                             input logic [gewr_pkg::WIND_W-1:0] v,
                             input logic [gewr_pkg::LON_W-1:0] lon);
      gewr_tb_pkg::grid_point_type p;
      p.u_grid = u;
      p.v_grid = v;
      p.point_longitude = lon;
      req_ch.valid           <= 1'b1;
      req_ch.u_grid          <= u;
      req_ch.v_grid          <= v;
      req_ch.point_longitude <= lon;
      do @(posedge clock); while (!(req_ch.valid && req_ch.ready));
      sb.note_point(p);
   endtask

   task automatic drain_points();
      req_ch.valid <= 1'b0;
      while (sb.pending_count() != 0) @(posedge clock);
   endtask

   function automatic logic [gewr_pkg::WIND_W-1:0] random_wind();
      case ($urandom_range(0, 9))
         0, 1, 2: return $urandom;
         3:       return $urandom_range(0, 1) ? WIND_MAX : WIND_MIN;
         default: return 32'(int'($urandom_range(0, 25600)) - 12800);
      endcase
   endfunction

   function automatic logic [gewr_pkg::LON_W-1:0] random_longitude();
      case ($urandom_range(0, 9))
         0:       return 25'($urandom);
         1:       return $urandom_range(0, 1) ? LON_MAX : LON_MIN;
         default: return 25'(int'($urandom_range(0, 23592960)) - 11796480);
      endcase
   endfunction

   function automatic gewr_tb_pkg::grid_point_type random_point();
      gewr_tb_pkg::grid_point_type     p;
      logic [gewr_pkg::WIND_W-1:0]     sentinel;
      p.u_grid = random_wind();
      p.v_grid = random_wind();
      p.point_longitude = random_longitude();
      if ($urandom_range(0, 6) == 0) begin
         sentinel = $urandom_range(0, 1) ? sb.missing_word : sb.unavail_word;
         case ($urandom_range(0, 2))
            0:       p.u_grid = sentinel;
            1:       p.v_grid = sentinel;
            default: begin
               p.u_grid = sentinel;
               p.v_grid = sentinel;
            end
         endcase
      end
      return p;
   endfunction

   function automatic logic [gewr_pkg::CONE_W-1:0] pick_cone();
      case ($urandom_range(0, 5))
         0:       return 16'sd20399;
         1:       return 16'sh7FFF;
         2:       return 16'sh8000;
         3:       return '0;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [gewr_pkg::LON_W-1:0] pick_center();
      case ($urandom_range(0, 5))
         0:       return -25'sd6389760;
         1:       return LON_MAX;
         2:       return LON_MIN;
         3:       return 25'($urandom);
         default: return 25'(int'($urandom_range(0, 23592960)) - 11796480);
      endcase
   endfunction

   function automatic logic [gewr_pkg::WIND_W-1:0] pick_sentinel(
         input logic [gewr_pkg::WIND_W-1:0] usual);
      case ($urandom_range(0, 5))
         0:       return usual;
         1:       return WIND_MAX;
         2:       return WIND_MIN;
         3:       return 32'(int'($urandom_range(0, 25600)) - 12800);
         default: return $urandom;
      endcase
   endfunction

   task automatic run_points(input int count);
      gewr_tb_pkg::grid_point_type p;
      for (int n = 0; n < count; n++) begin
         if (idling_on && $urandom_range(0, 5) == 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         p = random_point();
         send_point(p.u_grid, p.v_grid, p.point_longitude);
      end
   endtask

   initial begin
      rsp_ch.ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (long_stall_req) begin
            long_stall_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_STALL_CYCLES) @(posedge clock);
         end else if (idling_on && $urandom_range(0, 4) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_wind(rsp_ch.u_earth, rsp_ch.v_earth, rsp_ch.passed_through);
   end

   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || csr_we) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb_grid_to_earth_wind_rotation: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset                  = 1'b1;
      csr_we                 = 1'b0;
      csr_index              = gewr_pkg::CSR_CONE;
      csr_wdata              = '0;
      req_ch.valid           = 1'b0;
      req_ch.u_grid          = '0;
      req_ch.v_grid          = '0;
      req_ch.point_longitude = '0;
      idling_on              = 1'b0;
      long_stall_req         = 1'b0;
      quiet_cycles           = 0;
      sb = new(ROTATION_STEPS);
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Register defaults straight out of reset.
      send_point('0, '0, -25'sd6389760);
      send_point(WIND_MAX, WIND_MAX, -25'sd6389760);
      send_point(WIND_MIN, WIND_MIN, LON_MAX);
      send_point(WIND_MAX, WIND_MIN, LON_MIN);
      send_point(-32'sd25574400, 32'sd1234, '0);
      send_point(32'sd5, -32'sd25575168, '0);
      send_point(-32'sd25575168, -32'sd7, '0);
      send_point(32'sd100, -32'sd25574400, '0);
      drain_points();

      // Unit cone, angles at and beyond the fold, out-of-range longitude codes.
      load_settings(16'sh7FFF, '0, WIND_MAX, WIND_MIN);
      send_point(32'sd2560, -32'sd768, 25'(90 * DEGREE));
      send_point(32'sd2560, -32'sd768, 25'(-90 * DEGREE));
      send_point(-32'sd1000, 32'sd4000, 25'(135 * DEGREE));
      send_point(-32'sd1000, 32'sd4000, 25'(-135 * DEGREE));
      send_point(32'sd300000, -32'sd300000, LON_MAX);
      send_point(32'sd300000, -32'sd300000, LON_MIN);
      send_point(WIND_MAX, 32'sd5, '0);
      send_point(32'sd5, WIND_MIN, '0);
      send_point(WIND_MAX - 1, WIND_MIN + 1, 25'h0FFFFFF);
      send_point(WIND_MIN + 1, WIND_MAX - 1, 25'h1000000);
      send_point(32'sd12345, 32'sd678, 25'(DEGREE));
      drain_points();

      // Most negative cone with the widest longitude difference.
      load_settings(16'sh8000, LON_MAX, '0, '1);
      send_point(WIND_MAX - 1, 32'sd1, LON_MIN);
      send_point(WIND_MIN + 1, 32'sd2, LON_MIN);
      send_point('0, 32'sd3, '0);
      send_point(32'sd4, '1, '0);
      send_point('1, '0, 25'sd5);
      drain_points();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         load_settings(pick_cone(), pick_center(), pick_sentinel(-32'sd25574400),
                       pick_sentinel(-32'sd25575168));
         idling_on = (phase != 1) && (phase < RANDOM_PHASES - 2);
         // Back-pressure long enough to fill the pipeline while points keep coming.
         if (phase == 1) long_stall_req = 1'b1;
         run_points(PHASE_POINTS);
         drain_points();
      end

      repeat (ROTATION_STEPS + 20) @(posedge clock);
      if (sb.failures == 0 && sb.pending_count() == 0) begin
         $display("tb_grid_to_earth_wind_rotation: PASS");
      end else begin
         $display("tb_grid_to_earth_wind_rotation: FAIL");
      end
      $finish;
   end

endmodule
